>>> src/vlva_pkg.sv
// ----------------------------------------------------------------------------
// vlva_pkg: shared types and constants
// Entry layout, command/status groups and saturating helpers for the
// voxel length variance accumulator.
// ----------------------------------------------------------------------------
package vlva_pkg;

    localparam int CNT_W   = 24;
    localparam int SUM_W   = 40;
    localparam int M2_W    = 64;
    localparam int LEN_W   = 24;
    localparam int DIM_W   = 9;
    localparam int COORD_W = 8;
    localparam int FLAT_W  = 26;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [M2_W-1:0]  M2_MAX  = {M2_W{1'b1}};

    localparam logic [4:0] DIV_STEPS = 5'd24;

    localparam logic [1:0] KIND_HIT  = 2'd0;
    localparam logic [1:0] KIND_LEN  = 2'd1;
    localparam logic [1:0] KIND_VAR  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH  = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] hit_cnt;
        logic [CNT_W-1:0] smp_cnt;
        logic [SUM_W-1:0] len_sum;
        logic [SUM_W-1:0] hlen_sum;
        logic [CNT_W-1:0] wf_cnt;
        logic [LEN_W-1:0] wf_mean;
        logic [M2_W-1:0]  wf_m2;
    } entry_t;

    typedef struct packed {
        logic load_in;
        logic idx1;
        logic idx2;
        logic idx3;
        logic rd;
        logic upd;
        logic div_step;
        logic mean;
        logic mul;
        logic m2;
        logic wr;
        logic clr_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic oor;
        logic need_div;
    } stat_t;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] s,
                                                 input logic [LEN_W-1:0] v);
        logic [SUM_W:0] r;
        r = {1'b0, s} + {{(SUM_W+1-LEN_W){1'b0}}, v};
        return r[SUM_W] ? SUM_MAX : r[SUM_W-1:0];
    endfunction

endpackage

>>> src/vlva_ctrl.sv
// ----------------------------------------------------------------------------
// vlva_ctrl: sequencing state machine
// Clears the store after reset; each item runs index, then (if in range)
// read, update, divide/multiply when needed, write-back; then result load.
// ----------------------------------------------------------------------------
module vlva_ctrl #(
    parameter int AW = 16,
    parameter int CELL_COUNT = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  vlva_pkg::stat_t     stat,
    output vlva_pkg::cmd_t      cmd,
    output logic [AW-1:0]       clr_addr
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_IDX1  = 4'd2;
    localparam logic [3:0] ST_IDX2  = 4'd3;
    localparam logic [3:0] ST_IDX3  = 4'd4;
    localparam logic [3:0] ST_READ  = 4'd5;
    localparam logic [3:0] ST_RWAIT = 4'd6;
    localparam logic [3:0] ST_UPD   = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_MEAN  = 4'd9;
    localparam logic [3:0] ST_MUL   = 4'd10;
    localparam logic [3:0] ST_M2    = 4'd11;
    localparam logic [3:0] ST_WRITE = 4'd12;
    localparam logic [3:0] ST_LOAD  = 4'd13;

    localparam logic [AW-1:0] LAST = AW'(CELL_COUNT - 1);
    localparam logic [4:0] DIV_STEPS = vlva_pkg::DIV_STEPS;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          mv_reg, mv_next;
    logic          out_free;

    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;
    assign clr_addr = clr_reg;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_IDX1;
                end
            end
            ST_IDX1: begin cmd.idx1 = 1'b1; state_next = ST_IDX2; end
            ST_IDX2: begin cmd.idx2 = 1'b1; state_next = ST_IDX3; end
            ST_IDX3: begin cmd.idx3 = 1'b1; state_next = ST_READ; end
            ST_READ: begin
                if (stat.oor) begin
                    state_next = ST_LOAD;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = ST_RWAIT;
                end
            end
            ST_RWAIT: state_next = ST_UPD;
            ST_UPD: begin
                cmd.upd    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!stat.need_div) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_reg == DIV_STEPS - 1'b1) state_next = ST_MEAN;
                end
            end
            ST_MEAN:  begin cmd.mean = 1'b1; state_next = ST_MUL; end
            ST_MUL:   begin cmd.mul = 1'b1;  state_next = ST_M2; end
            ST_M2:    begin cmd.m2 = 1'b1;   state_next = ST_WRITE; end
            ST_WRITE: begin cmd.wr = 1'b1;   state_next = ST_LOAD; end
            ST_LOAD: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

>>> src/vlva_datapath.sv
// ----------------------------------------------------------------------------
// vlva_datapath: index math, voxel store, Welford arithmetic
// Holds the item, the store, a radix-2 divider and the result register.
// ----------------------------------------------------------------------------
module vlva_datapath #(
    parameter int AW = 16,
    parameter int CELL_COUNT = 65536
) (
    input  logic                              aclk,
    input  vlva_pkg::cmd_t                    cmd,
    output vlva_pkg::stat_t                   stat,
    input  logic [AW-1:0]                     clr_addr,
    input  logic [vlva_pkg::DIM_W-1:0]        grid_w,
    input  logic [vlva_pkg::DIM_W-1:0]        grid_h,
    input  logic [vlva_pkg::DIM_W-1:0]        grid_d,
    input  logic [1:0]                        s_kind,
    input  logic [vlva_pkg::COORD_W-1:0]      s_voxel_x,
    input  logic [vlva_pkg::COORD_W-1:0]      s_voxel_y,
    input  logic [vlva_pkg::COORD_W-1:0]      s_voxel_z,
    input  logic [vlva_pkg::LEN_W-1:0]        s_length,
    input  logic                              s_is_hit,
    output logic                              m_out_of_range,
    output logic [vlva_pkg::CNT_W-1:0]        m_hit_total,
    output logic [vlva_pkg::CNT_W-1:0]        m_sample_total,
    output logic [vlva_pkg::SUM_W-1:0]        m_length_total,
    output logic [vlva_pkg::SUM_W-1:0]        m_hit_length_total,
    output logic [vlva_pkg::LEN_W-1:0]        m_running_mean,
    output logic [vlva_pkg::M2_W-1:0]         m_running_m2
);

    localparam int LW = vlva_pkg::LEN_W;
    localparam logic [vlva_pkg::FLAT_W-1:0] CELLS = vlva_pkg::FLAT_W'(CELL_COUNT);

    vlva_pkg::entry_t mem [CELL_COUNT];
    vlva_pkg::entry_t rd_reg, ent_reg, ent_next;

    logic [1:0]                    kind_reg;
    logic [vlva_pkg::COORD_W-1:0]  x_reg, y_reg, z_reg;
    logic [LW-1:0]                 len_reg;
    logic                          hit_reg;
    logic [16:0]                   yw_reg, wh_reg;
    logic [vlva_pkg::FLAT_W-1:0]   zwh_reg, idx_reg;
    logic                          oor_reg, div_reg;
    logic signed [LW:0]            delta_reg, delta2_reg;
    logic [LW-1:0]                 quo_reg, rem_reg, dvs_reg;
    logic signed [2*LW+1:0]        prod_reg;

    logic [LW:0]                   rs;
    logic signed [LW+1:0]          mean_sum;
    logic [LW-1:0]                 mean_new;
    logic signed [LW:0]            dlt;
    logic [vlva_pkg::CNT_W-1:0]    n_new;
    logic [vlva_pkg::M2_W:0]       m2_sum;

    assign stat.oor      = oor_reg;
    assign stat.need_div = div_reg;

    assign rs = {rem_reg, quo_reg[LW-1]};
    assign dlt = $signed({1'b0, len_reg}) - $signed({1'b0, rd_reg.wf_mean});
    assign n_new = vlva_pkg::inc_sat(rd_reg.wf_cnt);
    assign mean_sum = $signed({2'b00, ent_reg.wf_mean})
                    + (delta_reg[LW] ? -$signed({2'b00, quo_reg})
                                     : $signed({2'b00, quo_reg}));
    // positive product stays below 2^48
    assign m2_sum = {1'b0, ent_reg.wf_m2} + {17'd0, prod_reg[2*LW-1:0]};

    always_comb begin
        if (mean_sum < 0)                              mean_new = '0;
        else if (mean_sum > $signed({2'b00, vlva_pkg::CNT_MAX})) mean_new = '1;
        else                                           mean_new = mean_sum[LW-1:0];
    end

    // per-kind update of the fetched entry
    always_comb begin
        ent_next = rd_reg;
        case (kind_reg)
            vlva_pkg::KIND_HIT: ent_next.hit_cnt = vlva_pkg::inc_sat(rd_reg.hit_cnt);
            vlva_pkg::KIND_LEN, vlva_pkg::KIND_VAR: begin
                ent_next.len_sum = vlva_pkg::add_sat(rd_reg.len_sum, len_reg);
                if (hit_reg) ent_next.hlen_sum = vlva_pkg::add_sat(rd_reg.hlen_sum, len_reg);
                ent_next.smp_cnt = vlva_pkg::inc_sat(rd_reg.smp_cnt);
                if (kind_reg == vlva_pkg::KIND_VAR) begin
                    ent_next.wf_cnt = n_new;
                    if (rd_reg.wf_cnt == '0) begin
                        ent_next.wf_mean = len_reg;
                        ent_next.wf_m2   = '0;
                    end
                end
            end
            default: ent_next = rd_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr)  mem[clr_addr] <= '0;
        else if (cmd.wr) mem[idx_reg[AW-1:0]] <= ent_reg;
        if (cmd.rd)      rd_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg <= s_kind;
            x_reg    <= s_voxel_x;
            y_reg    <= s_voxel_y;
            z_reg    <= s_voxel_z;
            len_reg  <= s_length;
            hit_reg  <= s_is_hit;
        end
        if (cmd.idx1) begin
            yw_reg <= {9'd0, y_reg} * {8'd0, grid_w};
            wh_reg <= {8'd0, grid_w} * {8'd0, grid_h};
        end
        if (cmd.idx2)
            zwh_reg <= {{(vlva_pkg::FLAT_W-17){1'b0}}, wh_reg}
                     * {{(vlva_pkg::FLAT_W-vlva_pkg::COORD_W){1'b0}}, z_reg};
        if (cmd.idx3) begin
            idx_reg <= vlva_pkg::FLAT_W'(x_reg) + vlva_pkg::FLAT_W'(yw_reg) + zwh_reg;
            oor_reg <= ({1'b0, x_reg} >= grid_w) || ({1'b0, y_reg} >= grid_h)
                    || ({1'b0, z_reg} >= grid_d)
                    || ((vlva_pkg::FLAT_W'(x_reg) + vlva_pkg::FLAT_W'(yw_reg)
                         + zwh_reg) >= CELLS);
        end
        if (cmd.upd) begin
            ent_reg   <= ent_next;
            div_reg   <= (kind_reg == vlva_pkg::KIND_VAR) && (rd_reg.wf_cnt != '0);
            delta_reg <= dlt;
            quo_reg   <= dlt[LW] ? LW'(-dlt) : dlt[LW-1:0];
            rem_reg   <= '0;
            dvs_reg   <= n_new;
        end
        if (cmd.div_step) begin
            if (rs >= {1'b0, dvs_reg}) begin
                rem_reg <= LW'(rs - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[LW-2:0], 1'b1};
            end else begin
                rem_reg <= rs[LW-1:0];
                quo_reg <= {quo_reg[LW-2:0], 1'b0};
            end
        end
        if (cmd.mean) begin
            ent_reg.wf_mean <= mean_new;
            delta2_reg      <= $signed({1'b0, len_reg}) - $signed({1'b0, mean_new});
        end
        if (cmd.mul) prod_reg <= delta_reg * delta2_reg;
        if (cmd.m2 && prod_reg > 0)
            ent_reg.wf_m2 <= m2_sum[vlva_pkg::M2_W] ? vlva_pkg::M2_MAX
                                                    : m2_sum[vlva_pkg::M2_W-1:0];
        if (cmd.load_out) begin
            m_out_of_range     <= oor_reg;
            m_hit_total        <= oor_reg ? '0 : ent_reg.hit_cnt;
            m_sample_total     <= oor_reg ? '0 : ent_reg.smp_cnt;
            m_length_total     <= oor_reg ? '0 : ent_reg.len_sum;
            m_hit_length_total <= oor_reg ? '0 : ent_reg.hlen_sum;
            m_running_mean     <= oor_reg ? '0 : ent_reg.wf_mean;
            m_running_m2       <= oor_reg ? '0 : ent_reg.wf_m2;
        end
    end

endmodule

>>> src/voxel_length_variance_accumulator.sv
// ----------------------------------------------------------------------------
// voxel_length_variance_accumulator: per-voxel hit/length/Welford accumulator
// Flow: later variance samples add the divide pass that kinds 0, 1, 3 and the
//   first variance sample skip; out-of-range items skip read and write.
// Throughput: one item at a time; the 24-step radix-2 divider sets the
//   longest item path; a held result stalls the next load.
// Reset: registers return to 64x64x16; then a clearing pass zeroes every
//   store cell, with s_ready low. Config writes are always taken.
// ----------------------------------------------------------------------------
module voxel_length_variance_accumulator #(
    parameter int CELL_COUNT = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write beat
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    // input item
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_voxel_x,
    input  logic [7:0]  s_voxel_y,
    input  logic [7:0]  s_voxel_z,
    input  logic [23:0] s_length,
    input  logic        s_is_hit,
    // result
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_of_range,
    output logic [23:0] m_hit_total,
    output logic [23:0] m_sample_total,
    output logic [39:0] m_length_total,
    output logic [39:0] m_hit_length_total,
    output logic [23:0] m_running_mean,
    output logic [63:0] m_running_m2
);

    // store address width; one bit minimum for a single-cell grid
    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    logic [vlva_pkg::DIM_W-1:0] width_reg, height_reg, depth_reg;
    vlva_pkg::cmd_t  cmd;
    vlva_pkg::stat_t stat;
    logic [AW-1:0]   clr_addr;

    // grid dimensions; a write to an unused index is taken and dropped
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd64;
            height_reg <= 9'd64;
            depth_reg  <= 9'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                vlva_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                vlva_pkg::REG_HEIGHT: height_reg <= cfg_data;
                vlva_pkg::REG_DEPTH:  depth_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    vlva_ctrl #(.AW(AW), .CELL_COUNT(CELL_COUNT)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd),
        .clr_addr (clr_addr)
    );

    // store and arithmetic
    vlva_datapath #(.AW(AW), .CELL_COUNT(CELL_COUNT)) u_dp (
        .aclk               (aclk),
        .cmd                (cmd),
        .stat               (stat),
        .clr_addr           (clr_addr),
        .grid_w             (width_reg),
        .grid_h             (height_reg),
        .grid_d             (depth_reg),
        .s_kind             (s_kind),
        .s_voxel_x          (s_voxel_x),
        .s_voxel_y          (s_voxel_y),
        .s_voxel_z          (s_voxel_z),
        .s_length           (s_length),
        .s_is_hit           (s_is_hit),
        .m_out_of_range     (m_out_of_range),
        .m_hit_total        (m_hit_total),
        .m_sample_total     (m_sample_total),
        .m_length_total     (m_length_total),
        .m_hit_length_total (m_hit_length_total),
        .m_running_mean     (m_running_mean),
        .m_running_m2       (m_running_m2)
    );

endmodule

>>> src/vlva_checker.sv
// ----------------------------------------------------------------------------
// vlva_checker: port-level checks
// Watches the top level's handshakes and result fields over time.
// ----------------------------------------------------------------------------
module vlva_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_out_of_range,
    input logic [23:0] m_hit_total,
    input logic [63:0] m_running_m2
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_total))
        else $error("result beat changed while stalled");

    // no result right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one item in flight
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    // flagged item reports an empty voxel
    a_oor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_hit_total == '0 && m_running_m2 == '0)
        else $error("out-of-range result carries data");

endmodule

bind voxel_length_variance_accumulator vlva_checker u_vlva_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_of_range (m_out_of_range),
    .m_hit_total    (m_hit_total),
    .m_running_m2   (m_running_m2)
);
